@@ rtl/core/gdta_pkg.sv @@
// ----------------------------------------------------------------------------
// gdta_pkg
// Shared types and constants of the grid disc threat accumulator.
// ----------------------------------------------------------------------------
package gdta_pkg;

   localparam int DEF_MAX_WIDTH         = 256;
   localparam int DEF_MAX_HEIGHT        = 256;
   localparam int DEF_THREAT_RESOLUTION = 8;

   localparam int CSR_DATA_W = 9;

   localparam logic [8:0]  RESET_DIM = 9'd64;
   localparam logic [23:0] RATE_CAP  = 24'd512000;
   localparam logic [30:0] ONE_Q8    = 31'd256;

   typedef enum logic [2:0] {
      OP_CLEAR    = 3'd0,
      OP_ADD      = 3'd1,
      OP_REMOVE   = 3'd2,
      OP_FINALIZE = 3'd3,
      OP_QUERY    = 3'd4
   } op_type;

   typedef enum logic {
      CSR_MAP_WIDTH  = 1'b0,
      CSR_MAP_HEIGHT = 1'b1
   } csr_index_type;

endpackage

@@ rtl/core/gdta_ram.sv @@
// ----------------------------------------------------------------------------
// gdta_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gdta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/grid_disc_threat_accumulator.sv @@
// ----------------------------------------------------------------------------
// grid_disc_threat_accumulator
// Threat grid with disc add/remove, grid-wide averaging and point query,
// driven by a sequencer around one shared multiplier and one radix-2 divider.
// ----------------------------------------------------------------------------
// Per transaction: query reads one cell (status 1 and threat 0 outside the grid);
// add/remove walk the rows and test the cells of the disc's bounding box;
// finalize sums the used cells, divides and adds the average to each of them;
// clear zeroes the whole grid; unarmed add and unused codes just respond. One
// transaction at a time, req_stall high meanwhile; a stalled response delays the
// next finish. Reset: synchronous; a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells zeroes the grid, average 1.0.
module grid_disc_threat_accumulator #(
   parameter int MAX_WIDTH         = gdta_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT        = gdta_pkg::DEF_MAX_HEIGHT,
   parameter int THREAT_RESOLUTION = gdta_pkg::DEF_THREAT_RESOLUTION
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [gdta_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_operation,
   input  logic signed [15:0]              req_pos_x,
   input  logic signed [15:0]              req_pos_z,
   input  logic [15:0]                     req_weapon_range,
   input  logic [23:0]                     req_damage_rate,
   input  logic                            req_armed,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [31:0]              rsp_threat,
   output logic [30:0]                     rsp_average,
   output logic                            rsp_status
);
   import gdta_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int TW    = AW + 1;
   localparam int D     = 8 * THREAT_RESOLUTION;
   localparam int S2    = 2 * D;
   localparam int K4    = 4 * D * D;
   localparam int K2    = 2 * D * D;
   localparam int RSW   = $clog2(2 * 65535 + 5 * D + 1);
   localparam int SUMW  = 32 + AW;
   localparam int DVW   = (AW + 1 > 10) ? AW + 1 : 10;
   localparam int CNTW  = $clog2(SUMW + 1);
   localparam int CW    = 17;
   localparam int LW    = 24;
   localparam int MW    = 27;
   localparam int PW    = 2 * MW;
   // reciprocal constants: exact floor division for 16-bit and (RSW+1)-bit operands
   localparam int DSH   = 16 + $clog2(D);
   localparam int DMUL  = ((1 << DSH) + D - 1) / D;
   localparam int KSH   = RSW + 1 + $clog2(S2);
   localparam int KMUL  = ((1 << KSH) + S2 - 1) / S2;

   typedef enum logic [31:0] {
      S_IDLE   = 32'h0000_0001,
      S_CLR    = 32'h0000_0002,
      S_DIV    = 32'h0000_0004,
      S_CX     = 32'h0000_0008,
      S_CZ     = 32'h0000_0010,
      S_RR     = 32'h0000_0020,
      S_LX     = 32'h0000_0040,
      S_LZ     = 32'h0000_0080,
      S_AX     = 32'h0000_0100,
      S_AZ     = 32'h0000_0200,
      S_X0     = 32'h0000_0400,
      S_Y0     = 32'h0000_0800,
      S_YB     = 32'h0000_1000,
      S_RBASE  = 32'h0000_2000,
      S_RCHK   = 32'h0000_4000,
      S_CCHK   = 32'h0000_8000,
      S_DZ     = 32'h0001_0000,
      S_K      = 32'h0002_0000,
      S_TEST   = 32'h0004_0000,
      S_WR     = 32'h0008_0000,
      S_QB     = 32'h0010_0000,
      S_QA     = 32'h0020_0000,
      S_QRD    = 32'h0040_0000,
      S_QOUT   = 32'h0080_0000,
      S_FTOT   = 32'h0100_0000,
      S_FSTART = 32'h0200_0000,
      S_SRD    = 32'h0400_0000,
      S_SACC   = 32'h0800_0000,
      S_FAVG   = 32'h1000_0000,
      S_FRD    = 32'h2000_0000,
      S_FWR    = 32'h4000_0000,
      S_DONE   = 32'h8000_0000
   } state_type;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s[32] != s[31]) begin
         sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat_add = s[31:0];
      end
   endfunction

   state_type state_ff, state_in, ret_ff, ret_in;
   logic boot_ff, boot_in;
   op_type op_ff, op_in;
   logic signed [15:0] px_ff, px_in, pz_ff, pz_in;
   logic slack_ff, slack_in;
   logic signed [31:0] delta_ff, delta_in;
   logic [RSW-1:0] rs_ff, rs_in;
   logic signed [CW-1:0] cx_ff, cx_in, cz_ff, cz_in;
   logic signed [PW-1:0] rr_ff, rr_in;
   logic signed [LW-1:0] limx_ff, limx_in, limz_ff, limz_in;
   logic signed [LW-1:0] x0s2_ff, x0s2_in, xs2_ff, xs2_in, ys2_ff, ys2_in;
   logic [XW-1:0] x0_ff, x0_in, x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [AW-1:0] base_ff, base_in, i_ff, i_in;
   logic signed [MW-1:0] sq_ff, sq_in;
   logic signed [PW-1:0] mul_p_ff;
   logic signed [MW-1:0] mul_a, mul_b;
   logic [SUMW-1:0] dv_quo_ff, dv_quo_in;
   logic [DVW-1:0] dv_rem_ff, dv_rem_in, dv_dvs_ff, dv_dvs_in;
   logic dv_neg_ff, dv_neg_in;
   logic [CNTW-1:0] dv_cnt_ff, dv_cnt_in;
   logic [DVW:0] dv_t;
   logic signed [SUMW:0] dv_q;
   logic [TW-1:0] total_ff, total_in;
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic [30:0] avg_ff, avg_in;
   logic [8:0] width_ff, height_ff;
   logic signed [31:0] res_threat_ff, res_threat_in;
   logic res_status_ff, res_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_threat_ff, rsp_threat_in;
   logic [30:0] rsp_average_ff, rsp_average_in;
   logic rsp_status_ff, rsp_status_in;

   logic [XW-1:0] uw;
   logic [YW-1:0] uh;
   logic signed [CW:0] dx_c, dz_c;
   logic signed [CW-1:0] cell_q;
   logic signed [CW:0] k_q, xst, zst;
   logic mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [31:0] mem_wdata, mem_rdata;

   assign uw = (32'(width_ff) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(width_ff);
   assign uh = (32'(height_ff) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(height_ff);
   assign dx_c = $signed({cx_ff[CW-1], cx_ff}) - $signed((CW + 1)'(x_ff));
   assign dz_c = $signed({cz_ff[CW-1], cz_ff}) - $signed((CW + 1)'(y_ff));

   // cell index magnitude and ceil(rs / S2) taken from the product register
   assign cell_q = CW'(mul_p_ff[PW-1:DSH]);
   assign k_q    = (CW + 1)'(mul_p_ff[PW-1:KSH]);
   assign xst    = $signed({cx_ff[CW-1], cx_ff}) - k_q;
   assign zst    = $signed({cz_ff[CW-1], cz_ff}) - k_q;

   // one quotient bit per cycle
   assign dv_t = {dv_rem_ff, dv_quo_ff[SUMW-1]};
   assign dv_q = dv_neg_ff ? -$signed({1'b0, dv_quo_ff}) : $signed({1'b0, dv_quo_ff});

   assign req_stall = (state_ff != S_IDLE);

   gdta_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_cells (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      ret_in         = ret_ff;
      boot_in        = boot_ff;
      op_in          = op_ff;
      px_in          = px_ff;
      pz_in          = pz_ff;
      slack_in       = slack_ff;
      delta_in       = delta_ff;
      rs_in          = rs_ff;
      cx_in          = cx_ff;
      cz_in          = cz_ff;
      rr_in          = rr_ff;
      limx_in        = limx_ff;
      limz_in        = limz_ff;
      x0s2_in        = x0s2_ff;
      xs2_in         = xs2_ff;
      ys2_in         = ys2_ff;
      x0_in          = x0_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      base_in        = base_ff;
      i_in           = i_ff;
      sq_in          = sq_ff;
      dv_quo_in      = dv_quo_ff;
      dv_rem_in      = dv_rem_ff;
      dv_dvs_in      = dv_dvs_ff;
      dv_neg_in      = dv_neg_ff;
      dv_cnt_in      = dv_cnt_ff;
      total_in       = total_ff;
      sum_in         = sum_ff;
      avg_in         = avg_ff;
      res_threat_in  = res_threat_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_threat_in  = rsp_threat_ff;
      rsp_average_in = rsp_average_ff;
      rsp_status_in  = rsp_status_ff;
      mul_a          = '0;
      mul_b          = '0;
      mem_we         = 1'b0;
      mem_waddr      = i_ff;
      mem_wdata      = '0;
      mem_raddr      = i_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = op_type'(req_operation);
               px_in         = req_pos_x;
               pz_in         = req_pos_z;
               slack_in      = (req_operation == OP_ADD);
               rs_in         = RSW'({req_weapon_range, 1'b0}) +
                               ((req_operation == OP_ADD) ? RSW'(5 * D) : RSW'(0));
               delta_in      = (req_operation == OP_ADD)
                               ? $signed(32'((req_damage_rate > RATE_CAP) ? RATE_CAP
                                                                          : req_damage_rate))
                               : -$signed(32'(req_damage_rate));
               res_threat_in = '0;
               res_status_in = 1'b0;
               i_in          = '0;
               priority case (req_operation)
                  OP_CLEAR:    state_in = S_CLR;
                  OP_ADD:      state_in = req_armed ? S_CX : S_DONE;
                  OP_REMOVE:   state_in = S_CX;
                  OP_QUERY:    state_in = S_CX;
                  OP_FINALIZE: state_in = S_FTOT;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            i_in      = i_ff + 1'b1;
            if (i_ff == AW'(DEPTH - 1)) begin
               state_in = boot_ff ? S_IDLE : S_DONE;
               boot_in  = 1'b0;
            end
         end
         S_DIV: begin
            if (dv_t >= {1'b0, dv_dvs_ff}) begin
               dv_rem_in = DVW'(dv_t - {1'b0, dv_dvs_ff});
               dv_quo_in = {dv_quo_ff[SUMW-2:0], 1'b1};
            end else begin
               dv_rem_in = dv_t[DVW-1:0];
               dv_quo_in = {dv_quo_ff[SUMW-2:0], 1'b0};
            end
            dv_cnt_in = dv_cnt_ff - 1'b1;
            if (dv_cnt_ff == CNTW'(1)) begin
               state_in = ret_ff;
            end
         end
         S_CX: begin
            // |pos| / D by reciprocal, sign restored afterwards
            mul_a    = MW'(px_ff[15] ? -17'(px_ff) : 17'(px_ff));
            mul_b    = MW'(DMUL);
            state_in = S_CZ;
         end
         S_CZ: begin
            cx_in    = px_ff[15] ? -cell_q : cell_q;
            mul_a    = MW'(pz_ff[15] ? -17'(pz_ff) : 17'(pz_ff));
            mul_b    = MW'(DMUL);
            state_in = (op_ff == OP_QUERY) ? S_QB : S_RR;
         end
         S_RR: begin
            cz_in    = pz_ff[15] ? -cell_q : cell_q;
            mul_a    = MW'(rs_ff);
            mul_b    = MW'(rs_ff);
            state_in = S_LX;
         end
         S_LX: begin
            rr_in    = mul_p_ff;
            mul_a    = MW'(cx_ff);
            mul_b    = MW'(S2);
            state_in = S_LZ;
         end
         S_LZ: begin
            limx_in  = LW'(mul_p_ff) + $signed(LW'(rs_ff));
            mul_a    = MW'(cz_ff);
            mul_b    = MW'(S2);
            state_in = S_AX;
         end
         S_AX: begin
            limz_in  = LW'(mul_p_ff) + $signed(LW'(rs_ff));
            mul_a    = MW'(rs_ff) + MW'(S2 - 1);
            mul_b    = MW'(KMUL);
            state_in = S_AZ;
         end
         S_AZ: begin
            // walk starts at c - ceil(rs / S2), floored at 0; past the edge is empty
            x0_in    = (xst < 0) ? '0 : (xst >= $signed((CW + 1)'(uw))) ? uw : XW'(xst);
            y_in     = (zst < 0) ? '0 : (zst >= $signed((CW + 1)'(uh))) ? uh : YW'(zst);
            state_in = S_X0;
         end
         S_X0: begin
            mul_a    = MW'(x0_ff);
            mul_b    = MW'(S2);
            state_in = S_Y0;
         end
         S_Y0: begin
            x0s2_in  = LW'(mul_p_ff);
            mul_a    = MW'(y_ff);
            mul_b    = MW'(S2);
            state_in = S_YB;
         end
         S_YB: begin
            ys2_in   = LW'(mul_p_ff);
            mul_a    = MW'(y_ff);
            mul_b    = MW'(uw);
            state_in = S_RBASE;
         end
         S_RBASE: begin
            base_in  = AW'(mul_p_ff);
            state_in = S_RCHK;
         end
         S_RCHK: begin
            if (y_ff < uh && ys2_ff < limz_ff) begin
               x_in     = x0_ff;
               xs2_in   = x0s2_ff;
               state_in = S_CCHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CCHK: begin
            mul_a = MW'(dx_c);
            mul_b = MW'(dx_c);
            if (x_ff < uw && xs2_ff < limx_ff) begin
               state_in = S_DZ;
            end else begin
               y_in     = y_ff + 1'b1;
               ys2_in   = ys2_ff + LW'(S2);
               base_in  = base_ff + AW'(uw);
               state_in = S_RCHK;
            end
         end
         S_DZ: begin
            sq_in    = MW'(mul_p_ff);
            mul_a    = MW'(dz_c);
            mul_b    = MW'(dz_c);
            state_in = S_K;
         end
         S_K: begin
            mul_a    = sq_ff + MW'(mul_p_ff);
            mul_b    = MW'(K4);
            state_in = S_TEST;
         end
         S_TEST: begin
            mem_raddr = base_ff + AW'(x_ff);
            if (mul_p_ff - (slack_ff ? PW'(K2) : PW'(0)) <= rr_ff) begin
               state_in = S_WR;
            end else begin
               x_in     = x_ff + 1'b1;
               xs2_in   = xs2_ff + LW'(S2);
               state_in = S_CCHK;
            end
         end
         S_WR: begin
            mem_we    = 1'b1;
            mem_waddr = base_ff + AW'(x_ff);
            mem_wdata = sat_add($signed(mem_rdata), delta_ff);
            x_in      = x_ff + 1'b1;
            xs2_in    = xs2_ff + LW'(S2);
            state_in  = S_CCHK;
         end
         S_QB: begin
            cz_in    = pz_ff[15] ? -cell_q : cell_q;
            state_in = S_QA;
         end
         S_QA: begin
            mul_a = MW'(cz_ff);
            mul_b = MW'(uw);
            if (cx_ff < 0 || cx_ff >= $signed(CW'(uw)) ||
                cz_ff < 0 || cz_ff >= $signed(CW'(uh))) begin
               res_status_in = 1'b1;
               state_in      = S_DONE;
            end else begin
               state_in = S_QRD;
            end
         end
         S_QRD: begin
            mem_raddr = AW'(mul_p_ff) + AW'(cx_ff);
            state_in  = S_QOUT;
         end
         S_QOUT: begin
            res_threat_in = $signed(mem_rdata);
            state_in      = S_DONE;
         end
         S_FTOT: begin
            mul_a    = MW'(uw);
            mul_b    = MW'(uh);
            state_in = S_FSTART;
         end
         S_FSTART: begin
            total_in = TW'(mul_p_ff);
            sum_in   = '0;
            i_in     = '0;
            if (mul_p_ff == '0) begin
               avg_in   = ONE_Q8;
               state_in = S_DONE;
            end else begin
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            mem_raddr = i_ff;
            state_in  = S_SACC;
         end
         S_SACC: begin
            sum_in = sum_ff + SUMW'($signed(mem_rdata));
            i_in   = i_ff + 1'b1;
            if (TW'(i_ff) == total_ff - 1'b1) begin
               dv_quo_in = sum_in[SUMW-1] ? SUMW'(-sum_in) : SUMW'(sum_in);
               dv_neg_in = sum_in[SUMW-1];
               dv_dvs_in = DVW'(total_ff);
               dv_rem_in = '0;
               dv_cnt_in = CNTW'(SUMW);
               ret_in    = S_FAVG;
               state_in  = S_DIV;
            end else begin
               state_in = S_SRD;
            end
         end
         S_FAVG: begin
            avg_in   = (dv_q < $signed((SUMW + 1)'(ONE_Q8))) ? ONE_Q8 : dv_q[30:0];
            i_in     = '0;
            state_in = S_FRD;
         end
         S_FRD: begin
            mem_raddr = i_ff;
            state_in  = S_FWR;
         end
         S_FWR: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = sat_add($signed(mem_rdata), $signed({1'b0, avg_ff}));
            i_in      = i_ff + 1'b1;
            state_in  = (TW'(i_ff) == total_ff - 1'b1) ? S_DONE : S_FRD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_threat_in  = res_threat_ff;
               rsp_average_in = avg_ff;
               rsp_status_in  = res_status_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         ret_ff       <= S_IDLE;
         boot_ff      <= 1'b1;
         i_ff         <= '0;
         dv_cnt_ff    <= '0;
         avg_ff       <= ONE_Q8;
         width_ff     <= RESET_DIM;
         height_ff    <= RESET_DIM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         boot_ff      <= boot_in;
         i_ff         <= i_in;
         dv_cnt_ff    <= dv_cnt_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_MAP_WIDTH:  width_ff  <= csr_wdata;
               CSR_MAP_HEIGHT: height_ff <= csr_wdata;
               default:        width_ff  <= width_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      px_ff          <= px_in;
      pz_ff          <= pz_in;
      slack_ff       <= slack_in;
      delta_ff       <= delta_in;
      rs_ff          <= rs_in;
      cx_ff          <= cx_in;
      cz_ff          <= cz_in;
      rr_ff          <= rr_in;
      limx_ff        <= limx_in;
      limz_ff        <= limz_in;
      x0s2_ff        <= x0s2_in;
      xs2_ff         <= xs2_in;
      ys2_ff         <= ys2_in;
      x0_ff          <= x0_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      base_ff        <= base_in;
      sq_ff          <= sq_in;
      mul_p_ff       <= mul_a * mul_b;
      dv_quo_ff      <= dv_quo_in;
      dv_rem_ff      <= dv_rem_in;
      dv_dvs_ff      <= dv_dvs_in;
      dv_neg_ff      <= dv_neg_in;
      total_ff       <= total_in;
      sum_ff         <= sum_in;
      res_threat_ff  <= res_threat_in;
      res_status_ff  <= res_status_in;
      rsp_threat_ff  <= rsp_threat_in;
      rsp_average_ff <= rsp_average_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_threat  = rsp_threat_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_status  = rsp_status_ff;

`ifndef SYNTHESIS
   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted transaction left sequencer idle");

   a_div_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dv_cnt_ff != '0))
      else $error("divider running with zero count");

   a_average_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_average >= ONE_Q8))
      else $error("average below 1.0");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_threat == 0))
      else $error("outside query returned nonzero threat");
`endif

endmodule
